/* rtl/core/tss_pkg.sv */
// ----------------------------------------------------------------------------
// Takeoff smoothstep trajectory package
// Shared constants, register indexes and phase codes of the takeoff trajectory
// generator and its pipelined divider.
// ----------------------------------------------------------------------------
package tss_pkg;

   // Default fixed-point layout of positions (Q16.16).
   localparam int FRAC_BITS = 16;

   // Normalized time is held in Q0.28.
   localparam int UB = 28;

   // Width of the takeoff duration register and of every divisor.
   localparam int DUR_W = 27;

   // Quotient bits produced by the velocity and acceleration dividers.
   localparam int DIV_QW = 44;

   // Quotient bits retired in each divider stage.
   localparam int DIV_STEP = 2;

   // Configuration port address width (eight 32-bit registers).
   localparam int CSR_AW = 5;

   localparam logic [31:0]      HOLD_RESET = 32'd10000000;
   localparam logic [DUR_W-1:0] DUR_RESET  = 27'd5000000;

   // Register indexes.
   localparam logic [2:0] REG_GROUND_X = 3'd0;
   localparam logic [2:0] REG_GROUND_Y = 3'd1;
   localparam logic [2:0] REG_GROUND_Z = 3'd2;
   localparam logic [2:0] REG_HOVER_X  = 3'd3;
   localparam logic [2:0] REG_HOVER_Y  = 3'd4;
   localparam logic [2:0] REG_HOVER_Z  = 3'd5;
   localparam logic [2:0] REG_HOLD     = 3'd6;
   localparam logic [2:0] REG_DURATION = 3'd7;

   // Phase codes.
   localparam logic [1:0] PH_HOLD    = 2'd0;
   localparam logic [1:0] PH_TAKEOFF = 2'd1;
   localparam logic [1:0] PH_HOVER   = 2'd2;

endpackage

/* rtl/core/tss_div_pipe.sv */
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Divides several lanes by one shared divisor, DIV_STEP quotient bits per
// stage. The starting remainder of each lane must be below the divisor.
// ----------------------------------------------------------------------------
module tss_div_pipe #(
   parameter int LANES = 1,
   parameter int DW    = tss_pkg::DUR_W,
   parameter int QW    = tss_pkg::DIV_QW,
   parameter int PW    = 2
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic                           in_valid,
   input  logic [LANES-1:0][DW-1:0]       in_rem,
   input  logic [LANES-1:0][QW-1:0]       in_num,
   input  logic [PW-1:0]                  in_pay,
   input  logic [DW-1:0]                  divisor,
   output logic                           out_valid,
   output logic [LANES-1:0][QW-1:0]       out_quo,
   output logic [PW-1:0]                  out_pay
);
   import tss_pkg::*;

   localparam int NS = QW / DIV_STEP;

   logic [NS-1:0]                         vld_ff;
   logic [NS-1:0]                         vld_in;
   logic [NS-1:0][LANES-1:0][DW-1:0]      rem_ff;
   logic [NS-1:0][LANES-1:0][DW-1:0]      rem_in;
   logic [NS-1:0][LANES-1:0][QW-1:0]      num_ff;
   logic [NS-1:0][LANES-1:0][QW-1:0]      num_in;
   logic [NS-1:0][LANES-1:0][QW-1:0]      quo_ff;
   logic [NS-1:0][LANES-1:0][QW-1:0]      quo_in;
   logic [NS-1:0][PW-1:0]                 pay_ff;
   logic [NS-1:0][PW-1:0]                 pay_in;

   logic [NS-1:0]                         src_vld;
   logic [NS-1:0][LANES-1:0][DW-1:0]      src_rem;
   logic [NS-1:0][LANES-1:0][QW-1:0]      src_num;
   logic [NS-1:0][LANES-1:0][QW-1:0]      src_quo;
   logic [NS-1:0][PW-1:0]                 src_pay;

   always_comb begin
      src_vld[0] = in_valid;
      src_rem[0] = in_rem;
      src_num[0] = in_num;
      src_quo[0] = '0;
      src_pay[0] = in_pay;
      for (int st = 1; st < NS; st++) begin
         src_vld[st] = vld_ff[st-1];
         src_rem[st] = rem_ff[st-1];
         src_num[st] = num_ff[st-1];
         src_quo[st] = quo_ff[st-1];
         src_pay[st] = pay_ff[st-1];
      end
   end

   always_comb begin
      logic [DW:0]   x;
      logic [DW-1:0] r;
      logic [QW-1:0] n;
      logic [QW-1:0] q;
      for (int st = 0; st < NS; st++) begin
         vld_in[st] = src_vld[st];
         pay_in[st] = src_pay[st];
         for (int ln = 0; ln < LANES; ln++) begin
            r = src_rem[st][ln];
            n = src_num[st][ln];
            q = src_quo[st][ln];
            for (int k = 0; k < DIV_STEP; k++) begin
               x = {r, n[QW-1]};
               n = {n[QW-2:0], 1'b0};
               if (x >= {1'b0, divisor}) begin
                  r = DW'(x - {1'b0, divisor});
                  q = {q[QW-2:0], 1'b1};
               end else begin
                  r = x[DW-1:0];
                  q = {q[QW-2:0], 1'b0};
               end
            end
            rem_in[st][ln] = r;
            num_in[st][ln] = n;
            quo_in[st][ln] = q;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         num_ff <= num_in;
         quo_ff <= quo_in;
         pay_ff <= pay_in;
      end
   end

   assign out_valid = vld_ff[NS-1];
   assign out_quo   = quo_ff[NS-1];
   assign out_pay   = pay_ff[NS-1];

endmodule

/* rtl/core/takeoff_smoothstep_trajectory.sv */
// ----------------------------------------------------------------------------
// Takeoff smoothstep trajectory
// Turns an elapsed time into a three-axis position, velocity and acceleration
// setpoint along a quintic smoothstep from a ground point to a hover point.
// ----------------------------------------------------------------------------
// The block accepts one request per clock while req_stall is low and returns
// each result in order. The pipeline holds three dividers that retire two
// quotient bits per stage: 14 stages for normalized time, 22 for velocity
// and the first acceleration scaling, and 22 for the second acceleration
// scaling, plus the stages of multiplies and bookkeeping. An output register
// and a one-entry skid register decouple the result side, so a stalled
// result holds the pipeline back by one request only. Registers may be
// rewritten only while no request is in flight.
module takeoff_smoothstep_trajectory #(
   parameter int FRAC_BITS = tss_pkg::FRAC_BITS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [tss_pkg::CSR_AW-1:0] paddr,
   input  logic [31:0]                pwdata,
   output logic [31:0]                prdata,
   output logic                       pready,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [31:0]                req_elapsed_us,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [31:0]                rsp_pos_x,
   output logic [31:0]                rsp_pos_y,
   output logic [31:0]                rsp_pos_z,
   output logic [31:0]                rsp_vel_x,
   output logic [31:0]                rsp_vel_y,
   output logic [31:0]                rsp_vel_z,
   output logic [31:0]                rsp_acc_x,
   output logic [31:0]                rsp_acc_y,
   output logic [31:0]                rsp_acc_z,
   output logic [1:0]                 rsp_phase
);
   import tss_pkg::*;

   localparam longint HOVER_Z_L = (longint'(12) << FRAC_BITS) / 10;
   localparam logic [31:0] HOVER_Z_RESET = HOVER_Z_L[31:0];
   localparam logic [63:0] MICRO = 64'd1000000;

   typedef struct packed {
      logic [1:0]       phase;
      logic [4:0][27:0] u;
   } pw_type;

   typedef struct packed {
      logic [1:0]         phase;
      logic [28:0]        s;
      logic signed [30:0] sd;
      logic signed [31:0] sdd;
   } sh_type;

   typedef struct packed {
      logic [1:0]       phase;
      logic [2:0][62:0] ps;
      logic [2:0][63:0] pv;
      logic [2:0][64:0] pa;
   } pr_type;

   typedef struct packed {
      logic [1:0]       phase;
      logic [2:0][31:0] pos;
      logic [2:0][35:0] p;
      logic [2:0][36:0] q;
   } tr_type;

   typedef struct packed {
      logic [1:0]       phase;
      logic [2:0][31:0] pos;
      logic [2:0]       neg_v;
      logic [2:0]       neg_a;
      logic [2:0][55:0] nv;
      logic [2:0][56:0] na;
   } sc_type;

   typedef struct packed {
      logic [1:0]       phase;
      logic [2:0][31:0] pos;
      logic [5:0]       neg;
      logic [5:0]       ovf;
   } pa_type;

   typedef struct packed {
      logic [1:0]       phase;
      logic [2:0][31:0] pos;
      logic [2:0][31:0] vel;
      logic [2:0]       neg;
      logic [2:0]       sat;
      logic [2:0][62:0] m;
   } ac_type;

   typedef struct packed {
      logic [1:0]       phase;
      logic [2:0][31:0] pos;
      logic [2:0][31:0] vel;
      logic [2:0]       neg;
      logic [2:0]       sat;
   } pb_type;

   typedef struct packed {
      logic [2:0][31:0] pos;
      logic [2:0][31:0] vel;
      logic [2:0][31:0] acc;
      logic [1:0]       phase;
   } result_type;

   // Saturates a signed magnitude to a 32-bit two's complement value.
   function automatic logic [31:0] sat_mag(input logic ovf, input logic neg,
                                           input logic [43:0] mag);
      logic [31:0] res;
      if (!neg) begin
         res = (ovf || mag > 44'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
      end else begin
         res = (ovf || mag > 44'h0_8000_0000) ? 32'h8000_0000 : (~mag[31:0] + 32'd1);
      end
      return res;
   endfunction

   function automatic logic [31:0] sat36(input logic signed [35:0] v);
      logic [31:0] res;
      if (v > 36'sh0_7FFF_FFFF) begin
         res = 32'h7FFF_FFFF;
      end else if (v < -36'sh0_8000_0000) begin
         res = 32'h8000_0000;
      end else begin
         res = v[31:0];
      end
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------------
   logic [2:0][31:0]  ground_ff, ground_in;
   logic [2:0][31:0]  hover_ff, hover_in;
   logic [31:0]       hold_ff, hold_in;
   logic [DUR_W-1:0]  dur_ff, dur_in;
   logic [2:0][32:0]  delta_ff, delta_in;
   logic              csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite;

   always_comb begin
      ground_in = ground_ff;
      hover_in  = hover_ff;
      hold_in   = hold_ff;
      dur_in    = dur_ff;
      if (csr_wr) begin
         unique case (paddr[4:2])
            REG_GROUND_X: ground_in[0] = pwdata;
            REG_GROUND_Y: ground_in[1] = pwdata;
            REG_GROUND_Z: ground_in[2] = pwdata;
            REG_HOVER_X:  hover_in[0]  = pwdata;
            REG_HOVER_Y:  hover_in[1]  = pwdata;
            REG_HOVER_Z:  hover_in[2]  = pwdata;
            REG_HOLD:     hold_in      = pwdata;
            REG_DURATION: dur_in       = pwdata[DUR_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (paddr[4:2])
         REG_GROUND_X: prdata = ground_ff[0];
         REG_GROUND_Y: prdata = ground_ff[1];
         REG_GROUND_Z: prdata = ground_ff[2];
         REG_HOVER_X:  prdata = hover_ff[0];
         REG_HOVER_Y:  prdata = hover_ff[1];
         REG_HOVER_Z:  prdata = hover_ff[2];
         REG_HOLD:     prdata = hold_ff;
         REG_DURATION: prdata = {{(32-DUR_W){1'b0}}, dur_ff};
      endcase
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         delta_in[k] = 33'($signed({hover_ff[k][31], hover_ff[k]})
                          - $signed({ground_ff[k][31], ground_ff[k]}));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ground_ff <= '0;
         hover_ff  <= {HOVER_Z_RESET, 32'd0, 32'd0};
         hold_ff   <= HOLD_RESET;
         dur_ff    <= DUR_RESET;
      end else begin
         ground_ff <= ground_in;
         hover_ff  <= hover_in;
         hold_ff   <= hold_in;
         dur_ff    <= dur_in;
      end
   end

   // The span is rederived every cycle; the user must not rewrite the
   // registers while a request is in flight, which the block does not enforce.
   always_ff @(posedge clock) begin
      delta_ff <= delta_in;
   end

   // ------------------------------------------------------------------------
   // Pipeline control
   // ------------------------------------------------------------------------
   logic       en;
   logic       skid_valid_ff, skid_valid_in;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type skid_ff, skid_in;
   result_type out_ff, out_in;

   assign en        = ~skid_valid_ff;
   assign req_stall = skid_valid_ff;

   // ------------------------------------------------------------------------
   // Stage 1: phase decision
   // ------------------------------------------------------------------------
   logic             s1_valid_ff;
   logic [1:0]       s1_phase_ff, s1_phase_in;
   logic [DUR_W-1:0] s1_dt_ff, s1_dt_in;

   always_comb begin
      logic [31:0] dt;
      dt          = req_elapsed_us - hold_ff;
      s1_dt_in    = '0;
      if (req_elapsed_us < hold_ff) begin
         s1_phase_in = PH_HOLD;
      end else if (dt < {{(32-DUR_W){1'b0}}, dur_ff}) begin
         s1_phase_in = PH_TAKEOFF;
         s1_dt_in    = dt[DUR_W-1:0];
      end else begin
         s1_phase_in = PH_HOVER;
      end
   end

   // ------------------------------------------------------------------------
   // Normalized time u = dt * 2^28 / D
   // ------------------------------------------------------------------------
   logic        du_valid;
   logic [27:0] du_quo;
   logic [1:0]  du_phase;

   tss_div_pipe #(
      .LANES (1),
      .DW    (DUR_W),
      .QW    (UB),
      .PW    (2)
   ) u_div_u (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s1_valid_ff),
      .in_rem    (s1_dt_ff),
      .in_num    ('0),
      .in_pay    (s1_phase_ff),
      .divisor   (dur_ff),
      .out_valid (du_valid),
      .out_quo   (du_quo),
      .out_pay   (du_phase)
   );

   // ------------------------------------------------------------------------
   // Powers of u, one multiplier per stage
   // ------------------------------------------------------------------------
   logic [3:0]   pw_valid_ff;
   pw_type [3:0] pw_ff, pw_in;
   pw_type [3:0] pw_src;

   always_comb begin
      logic [55:0] prod;
      pw_src[0].phase = du_phase;
      pw_src[0].u     = {112'd0, du_quo};
      for (int i = 1; i < 4; i++) begin
         pw_src[i] = pw_ff[i-1];
      end
      for (int i = 0; i < 4; i++) begin
         pw_in[i]        = pw_src[i];
         prod            = pw_src[i].u[i] * pw_src[i].u[0];
         pw_in[i].u[i+1] = prod[55:UB];
      end
   end

   // ------------------------------------------------------------------------
   // Shape polynomials
   // ------------------------------------------------------------------------
   logic   sh_valid_ff;
   sh_type sh_ff, sh_in;

   always_comb begin
      logic signed [39:0] e [5];
      logic signed [39:0] s_full;
      logic signed [39:0] sd_full;
      logic signed [39:0] sdd_full;
      for (int k = 0; k < 5; k++) begin
         e[k] = $signed({12'd0, pw_ff[3].u[k]});
      end
      s_full   = 40'sd10 * e[2] - 40'sd15 * e[3] + 40'sd6 * e[4];
      sd_full  = 40'sd30 * e[1] - 40'sd60 * e[2] + 40'sd30 * e[3];
      sdd_full = 40'sd60 * e[0] - 40'sd180 * e[1] + 40'sd120 * e[2];
      sh_in.phase = pw_ff[3].phase;
      if (s_full < 40'sd0) begin
         sh_in.s = '0;
      end else if (s_full > 40'sd268435456) begin
         sh_in.s = 29'h1000_0000;
      end else begin
         sh_in.s = s_full[28:0];
      end
      sh_in.sd  = sd_full[30:0];
      sh_in.sdd = sdd_full[31:0];
   end

   // ------------------------------------------------------------------------
   // Span products
   // ------------------------------------------------------------------------
   logic   pr_valid_ff;
   pr_type pr_ff, pr_in;

   always_comb begin
      logic signed [62:0] ps;
      logic signed [63:0] pv;
      logic signed [64:0] pa;
      pr_in.phase = sh_ff.phase;
      for (int k = 0; k < 3; k++) begin
         ps = $signed(delta_ff[k]) * $signed({1'b0, sh_ff.s});
         pv = $signed(delta_ff[k]) * sh_ff.sd;
         pa = $signed(delta_ff[k]) * sh_ff.sdd;
         pr_in.ps[k] = ps;
         pr_in.pv[k] = pv;
         pr_in.pa[k] = pa;
      end
   end

   // ------------------------------------------------------------------------
   // Scale by 2^-28 rounding toward zero, position sum
   // ------------------------------------------------------------------------
   logic   tr_valid_ff;
   tr_type tr_ff, tr_in;

   always_comb begin
      logic signed [62:0] ts;
      logic signed [63:0] tv;
      logic signed [64:0] ta;
      logic signed [35:0] sum;
      tr_in.phase = pr_ff.phase;
      for (int k = 0; k < 3; k++) begin
         ts = $signed(pr_ff.ps[k]) + $signed({35'd0, {UB{pr_ff.ps[k][62]}}});
         tv = $signed(pr_ff.pv[k]) + $signed({36'd0, {UB{pr_ff.pv[k][63]}}});
         ta = $signed(pr_ff.pa[k]) + $signed({37'd0, {UB{pr_ff.pa[k][64]}}});
         sum = $signed({{4{ground_ff[k][31]}}, ground_ff[k]})
               + $signed({ts[62], ts[62:UB]});
         tr_in.pos[k] = sat36(sum);
         tr_in.p[k]   = tv[63:UB];
         tr_in.q[k]   = ta[64:UB];
      end
   end

   // ------------------------------------------------------------------------
   // Magnitudes times one million
   // ------------------------------------------------------------------------
   logic   sc_valid_ff;
   sc_type sc_ff, sc_in;

   always_comb begin
      logic [35:0] pm;
      logic [36:0] qm;
      logic [63:0] nv;
      logic [63:0] na;
      sc_in.phase = tr_ff.phase;
      sc_in.pos   = tr_ff.pos;
      for (int k = 0; k < 3; k++) begin
         pm = tr_ff.p[k][35] ? (~tr_ff.p[k] + 36'd1) : tr_ff.p[k];
         qm = tr_ff.q[k][36] ? (~tr_ff.q[k] + 37'd1) : tr_ff.q[k];
         nv = {28'd0, pm} * MICRO;
         na = {27'd0, qm} * MICRO;
         sc_in.neg_v[k] = tr_ff.p[k][35];
         sc_in.neg_a[k] = tr_ff.q[k][36];
         sc_in.nv[k]    = nv[55:0];
         sc_in.na[k]    = na[56:0];
      end
   end

   // ------------------------------------------------------------------------
   // Velocity and first acceleration divisions
   // ------------------------------------------------------------------------
   logic [5:0][DUR_W-1:0]  da_rem;
   logic [5:0][DIV_QW-1:0] da_num;
   pa_type                 da_pay_in, da_pay;
   logic                   da_valid;
   logic [5:0][DIV_QW-1:0] da_quo;

   always_comb begin
      logic [DUR_W-1:0] hi;
      logic             ovf;
      da_pay_in.phase = sc_ff.phase;
      da_pay_in.pos   = sc_ff.pos;
      for (int k = 0; k < 3; k++) begin
         hi  = DUR_W'(sc_ff.nv[k][55:DIV_QW]);
         ovf = hi >= dur_ff;
         da_pay_in.neg[k] = sc_ff.neg_v[k];
         da_pay_in.ovf[k] = ovf;
         da_rem[k]        = ovf ? '0 : hi;
         da_num[k]        = sc_ff.nv[k][DIV_QW-1:0];
         hi  = DUR_W'(sc_ff.na[k][56:DIV_QW]);
         ovf = hi >= dur_ff;
         da_pay_in.neg[k+3] = sc_ff.neg_a[k];
         da_pay_in.ovf[k+3] = ovf;
         da_rem[k+3]        = ovf ? '0 : hi;
         da_num[k+3]        = sc_ff.na[k][DIV_QW-1:0];
      end
   end

   tss_div_pipe #(
      .LANES (6),
      .DW    (DUR_W),
      .QW    (DIV_QW),
      .PW    ($bits(pa_type))
   ) u_div_a (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sc_valid_ff),
      .in_rem    (da_rem),
      .in_num    (da_num),
      .in_pay    (da_pay_in),
      .divisor   (dur_ff),
      .out_valid (da_valid),
      .out_quo   (da_quo),
      .out_pay   (da_pay)
   );

   // ------------------------------------------------------------------------
   // Velocity result, acceleration limit, second scaling by one million
   // ------------------------------------------------------------------------
   logic   ac_valid_ff;
   ac_type ac_ff, ac_in;

   always_comb begin
      logic [DIV_QW-1:0] r;
      ac_in.phase = da_pay.phase;
      ac_in.pos   = da_pay.pos;
      for (int k = 0; k < 3; k++) begin
         ac_in.vel[k] = sat_mag(da_pay.ovf[k], da_pay.neg[k], da_quo[k]);
         r            = da_quo[k+3];
         // At 2^43 or above the intermediate rate saturates the result outright.
         ac_in.sat[k] = da_pay.ovf[k+3] | r[DIV_QW-1];
         ac_in.neg[k] = da_pay.neg[k+3];
         ac_in.m[k]   = 63'({20'd0, r[DIV_QW-2:0]} * MICRO);
      end
   end

   // ------------------------------------------------------------------------
   // Second acceleration division
   // ------------------------------------------------------------------------
   logic [2:0][DUR_W-1:0]  db_rem;
   logic [2:0][DIV_QW-1:0] db_num;
   pb_type                 db_pay_in, db_pay;
   logic                   db_valid;
   logic [2:0][DIV_QW-1:0] db_quo;

   always_comb begin
      logic [DUR_W-1:0] hi;
      logic             ovf;
      db_pay_in.phase = ac_ff.phase;
      db_pay_in.pos   = ac_ff.pos;
      db_pay_in.vel   = ac_ff.vel;
      db_pay_in.neg   = ac_ff.neg;
      for (int k = 0; k < 3; k++) begin
         hi  = DUR_W'(ac_ff.m[k][62:DIV_QW]);
         ovf = hi >= dur_ff;
         db_pay_in.sat[k] = ac_ff.sat[k] | ovf;
         db_rem[k]        = ovf ? '0 : hi;
         db_num[k]        = ac_ff.m[k][DIV_QW-1:0];
      end
   end

   tss_div_pipe #(
      .LANES (3),
      .DW    (DUR_W),
      .QW    (DIV_QW),
      .PW    ($bits(pb_type))
   ) u_div_b (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (ac_valid_ff),
      .in_rem    (db_rem),
      .in_num    (db_num),
      .in_pay    (db_pay_in),
      .divisor   (dur_ff),
      .out_valid (db_valid),
      .out_quo   (db_quo),
      .out_pay   (db_pay)
   );

   // ------------------------------------------------------------------------
   // Result assembly and output registers
   // ------------------------------------------------------------------------
   result_type fin;

   always_comb begin
      fin.phase = db_pay.phase;
      unique case (db_pay.phase)
         PH_HOLD: begin
            fin.pos = ground_ff;
            fin.vel = '0;
            fin.acc = '0;
         end
         PH_TAKEOFF: begin
            fin.pos = db_pay.pos;
            fin.vel = db_pay.vel;
            for (int k = 0; k < 3; k++) begin
               fin.acc[k] = sat_mag(db_pay.sat[k], db_pay.neg[k], db_quo[k]);
            end
         end
         default: begin
            fin.pos = hover_ff;
            fin.vel = '0;
            fin.acc = '0;
         end
      endcase
   end

   always_comb begin
      logic out_free;
      out_free      = ~rsp_valid_ff | ~rsp_stall;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (out_free) begin
            rsp_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (out_free) begin
         rsp_valid_in = db_valid;
         out_in       = fin;
      end else if (db_valid) begin
         // The output is held, so the request leaving the pipeline parks here.
         skid_valid_in = 1'b1;
         skid_in       = fin;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         pw_valid_ff   <= '0;
         sh_valid_ff   <= 1'b0;
         pr_valid_ff   <= 1'b0;
         tr_valid_ff   <= 1'b0;
         sc_valid_ff   <= 1'b0;
         ac_valid_ff   <= 1'b0;
         skid_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (en) begin
            s1_valid_ff <= req_valid;
            pw_valid_ff <= {pw_valid_ff[2:0], du_valid};
            sh_valid_ff <= pw_valid_ff[3];
            pr_valid_ff <= sh_valid_ff;
            tr_valid_ff <= pr_valid_ff;
            sc_valid_ff <= tr_valid_ff;
            ac_valid_ff <= da_valid;
         end
         skid_valid_ff <= skid_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_phase_ff <= s1_phase_in;
         s1_dt_ff    <= s1_dt_in;
         pw_ff       <= pw_in;
         sh_ff       <= sh_in;
         pr_ff       <= pr_in;
         tr_ff       <= tr_in;
         sc_ff       <= sc_in;
         ac_ff       <= ac_in;
      end
      skid_ff <= skid_in;
      out_ff  <= out_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pos_x = out_ff.pos[0];
   assign rsp_pos_y = out_ff.pos[1];
   assign rsp_pos_z = out_ff.pos[2];
   assign rsp_vel_x = out_ff.vel[0];
   assign rsp_vel_y = out_ff.vel[1];
   assign rsp_vel_z = out_ff.vel[2];
   assign rsp_acc_x = out_ff.acc[0];
   assign rsp_acc_y = out_ff.acc[1];
   assign rsp_acc_z = out_ff.acc[2];
   assign rsp_phase = out_ff.phase;

`ifndef ASSERT_OFF
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid register holds a request while the output is empty");

   a_skid_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(rsp_valid_ff && rsp_stall))
      else $error("skid register filled without a stalled output");

   a_still_motion: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_phase != PH_TAKEOFF) |->
      (rsp_vel_x == 32'd0 && rsp_vel_y == 32'd0 && rsp_vel_z == 32'd0 &&
       rsp_acc_x == 32'd0 && rsp_acc_y == 32'd0 && rsp_acc_z == 32'd0))
      else $error("motion reported outside the takeoff phase");
`endif

endmodule

/* tb/takeoff_smoothstep_trajectory_checker.sv */
// ----------------------------------------------------------------------------
// Takeoff trajectory checker
// Follows register writes on the configuration bus, predicts the setpoint for
// every request the block takes and compares it as a whole and in order
// with every result that leaves the block.
// ----------------------------------------------------------------------------
module takeoff_smoothstep_trajectory_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [tss_pkg::CSR_AW-1:0] paddr,
   input  logic [31:0]                pwdata,
   input  logic                       pready,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic [31:0]                req_elapsed_us,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic [31:0]                rsp_pos_x,
   input  logic [31:0]                rsp_pos_y,
   input  logic [31:0]                rsp_pos_z,
   input  logic [31:0]                rsp_vel_x,
   input  logic [31:0]                rsp_vel_y,
   input  logic [31:0]                rsp_vel_z,
   input  logic [31:0]                rsp_acc_x,
   input  logic [31:0]                rsp_acc_y,
   input  logic [31:0]                rsp_acc_z,
   input  logic [1:0]                 rsp_phase,
   output int                         fails,
   output int                         pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import tss_pkg::*;

   typedef struct packed {
      logic [2:0][31:0] pos;
      logic [2:0][31:0] vel;
      logic [2:0][31:0] acc;
      logic [1:0]       phase;
   } setpoint_type;

   int               ground [3];
   int               hover [3];
   int unsigned      hold_us;
   logic [DUR_W-1:0] dur_us;
   setpoint_type     setpoints_due[$];
   int               fail_count;

   function automatic logic [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'h7fffffff;
      if (v < -64'sd2147483648) return 32'h80000000;
      return v[31:0];
   endfunction

   function automatic setpoint_type trajectory_at(logic [31:0] t);
      setpoint_type sp;
      longint unsigned dt;
      longint d, u1, u2, u3, u4, u5, s, sd, sdd, delta, p, q, r;
      sp = '0;
      d = longint'(dur_us);
      if (t < hold_us) begin
         sp.phase = PH_HOLD;
         for (int k = 0; k < 3; k++) sp.pos[k] = ground[k];
      end else if (longint'(t) - longint'(hold_us) < d) begin
         sp.phase = PH_TAKEOFF;
         dt = longint'(t) - longint'(hold_us);
         u1 = longint'((dt << UB) / longint'(dur_us));
         u2 = (u1 * u1) >>> UB;
         u3 = (u2 * u1) >>> UB;
         u4 = (u3 * u1) >>> UB;
         u5 = (u4 * u1) >>> UB;
         s   = 10 * u3 - 15 * u4 + 6 * u5;
         sd  = 30 * u2 - 60 * u3 + 30 * u4;
         sdd = 60 * u1 - 180 * u2 + 120 * u3;
         if (s < 0) s = 0;
         if (s > (64'sd1 <<< UB)) s = 64'sd1 <<< UB;
         for (int k = 0; k < 3; k++) begin
            delta = longint'(hover[k]) - longint'(ground[k]);
            p = (delta * sd) / (64'sd1 <<< UB);
            q = (delta * sdd) / (64'sd1 <<< UB);
            sp.pos[k] = clamp32(longint'(ground[k]) + (delta * s) / (64'sd1 <<< UB));
            sp.vel[k] = clamp32((p * 1000000) / d);
            r = (q * 1000000) / d;
            // Past this quotient the second scaling would overflow, so it saturates.
            if (r >= (64'sd1 <<< 43)) sp.acc[k] = 32'h7fffffff;
            else if (r <= -(64'sd1 <<< 43)) sp.acc[k] = 32'h80000000;
            else sp.acc[k] = clamp32((r * 1000000) / d);
         end
      end else begin
         sp.phase = PH_HOVER;
         for (int k = 0; k < 3; k++) sp.pos[k] = hover[k];
      end
      return sp;
   endfunction

   always @(posedge clock) begin
      setpoint_type want, got;
      if (reset) begin
         ground = '{0, 0, 0};
         hover = '{0, 0, 78643};
         hold_us = HOLD_RESET;
         dur_us = DUR_RESET;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[4:2])
               REG_GROUND_X: ground[0] = pwdata;
               REG_GROUND_Y: ground[1] = pwdata;
               REG_GROUND_Z: ground[2] = pwdata;
               REG_HOVER_X:  hover[0] = pwdata;
               REG_HOVER_Y:  hover[1] = pwdata;
               REG_HOVER_Z:  hover[2] = pwdata;
               REG_HOLD:     hold_us = pwdata;
               REG_DURATION: dur_us = pwdata[DUR_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            setpoints_due.push_back(trajectory_at(req_elapsed_us));
         if (rsp_valid && !rsp_stall) begin
            got.pos = {rsp_pos_z, rsp_pos_y, rsp_pos_x};
            got.vel = {rsp_vel_z, rsp_vel_y, rsp_vel_x};
            got.acc = {rsp_acc_z, rsp_acc_y, rsp_acc_x};
            got.phase = rsp_phase;
            if (setpoints_due.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected result: %p", got);
            end else begin
               want = setpoints_due.pop_front();
               if (want != got) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: expected %p, got %p", want, got);
               end
            end
         end
      end
      fails = fail_count;
      pending = setpoints_due.size();
   end

endmodule

/* tb/takeoff_smoothstep_trajectory_tb.sv */
// ----------------------------------------------------------------------------
// Takeoff trajectory testbench
// Programs the ground point, hover point and timing through the register
// port, sends directed and random elapsed-time requests in bursts while the
// result side stalls, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module takeoff_smoothstep_trajectory_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tss_pkg::*;

   localparam int IDLE_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 80;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [CSR_AW-1:0] paddr = '0;
   logic [31:0] pwdata = '0, prdata;
   logic pready;
   logic req_valid = 1'b0, req_stall;
   logic [31:0] req_elapsed_us = '0;
   logic rsp_valid, rsp_stall = 1'b0;
   logic [31:0] rsp_pos_x, rsp_pos_y, rsp_pos_z;
   logic [31:0] rsp_vel_x, rsp_vel_y, rsp_vel_z;
   logic [31:0] rsp_acc_x, rsp_acc_y, rsp_acc_z;
   logic [1:0]  rsp_phase;
   int fails, pending;
   int idle_cycles = 0;
   bit long_holdoff = 0;
   int unsigned cur_hold;
   int unsigned cur_dur;
   int burst_left = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   takeoff_smoothstep_trajectory uut (.*);
   takeoff_smoothstep_trajectory_checker chk (.*);

   // Watchdog: a run that stops moving requests and results is a failure.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         idle_cycles <= 0;
      else if (idle_cycles >= IDLE_LIMIT) begin
         $display("takeoff_smoothstep_trajectory_tb: done, errors");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   // Result side: stretches of different stall patterns, one long hold-off.
   initial begin
      int mode, len;
      rsp_stall = 1'b0;
      forever begin
         if (long_holdoff) begin
            @(negedge clock) rsp_stall <= 1'b1;
            repeat (400) @(negedge clock);
            long_holdoff = 0;
         end
         mode = $urandom_range(0, 3);
         len = $urandom_range(1, 60);
         repeat (len) begin
            @(negedge clock);
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= $urandom_range(0, 1);
               2: rsp_stall <= ($urandom_range(0, 3) == 0);
               default: rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   task automatic csr_write(logic [2:0] idx, logic [31:0] value);
      @(negedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= {idx, 2'b00}; pwdata <= value;
      @(negedge clock) penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      if (idx == REG_HOLD) cur_hold = value;
      if (idx == REG_DURATION) cur_dur = value[DUR_W-1:0];
   endtask

   task automatic drain();
      do @(posedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Sender: bursts of random length separated by random gaps.
   task automatic send_request(logic [31:0] t);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 20);
         if ($urandom_range(0, 2) != 0) begin
            @(negedge clock) req_valid <= 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_elapsed_us <= t;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic stop_sending();
      @(negedge clock) req_valid <= 1'b0;
   endtask

   task automatic program_all(int gx, int gy, int gz, int hx, int hy, int hz,
                              logic [31:0] hold, logic [31:0] dur);
      csr_write(REG_GROUND_X, gx);
      csr_write(REG_GROUND_Y, gy);
      csr_write(REG_GROUND_Z, gz);
      csr_write(REG_HOVER_X, hx);
      csr_write(REG_HOVER_Y, hy);
      csr_write(REG_HOVER_Z, hz);
      csr_write(REG_HOLD, hold);
      csr_write(REG_DURATION, dur);
   endtask

   // Times at and around the edges of the takeoff window.
   task automatic send_boundaries();
      logic [31:0] h, d;
      h = cur_hold; d = cur_dur;
      send_request(0);
      send_request(h - 1);
      send_request(h);
      send_request(h + 1);
      send_request(h + d / 4);
      send_request(h + d / 2);
      send_request(h + d - 1);
      send_request(h + d);
      send_request(32'hffffffff);
      stop_sending();
   endtask

   task automatic send_random(int count);
      logic [31:0] t;
      repeat (count) begin
         case ($urandom_range(0, 9))
            0, 1: t = $urandom;
            2: t = cur_hold + $urandom_range(0, 3) - 2;
            3: t = cur_hold + cur_dur + $urandom_range(0, 3) - 2;
            default: t = cur_hold + $urandom_range(0, cur_dur);
         endcase
         send_request(t);
      end
      stop_sending();
   endtask

   function automatic int random_point();
      case ($urandom_range(0, 4))
         0: return 32'h80000000;
         1: return 32'h7fffffff;
         2: return $urandom;
         default: return $signed($urandom_range(0, 20 << 16)) - (10 << 16);
      endcase
   endfunction

   function automatic logic [31:0] random_duration();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return $urandom_range(1, 999);
         2: return 27'h7ffffff;
         3: return $urandom_range(1000, 5000);
         4: return $urandom;
         default: return $urandom_range(1000, 100000000);
      endcase
   endfunction

   initial begin
      cur_hold = HOLD_RESET;
      cur_dur = DUR_RESET;
      repeat (7) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // Reset values, then extreme points and short, empty and long windows.
      send_boundaries();
      drain();
      program_all(32'h80000000, 32'h7fffffff, 0, 32'h7fffffff, 32'h80000000,
                  1 << 16, 0, 1000);
      send_boundaries();
      drain();
      csr_write(REG_DURATION, 0);
      send_boundaries();
      drain();
      program_all(-(3 << 16), 5 << 16, 0, 2 << 16, -(1 << 16), 3 << 16,
                  32'hffffffff, 27'h7ffffff);
      send_boundaries();
      drain();
      csr_write(REG_HOLD, 1000);
      csr_write(REG_DURATION, 1);
      send_boundaries();
      drain();

      // The first random phase also holds off results long enough to back up.
      long_holdoff = 1;
      for (int ph = 0; ph < 4; ph++) begin
         program_all(random_point(), random_point(), random_point(),
                     random_point(), random_point(), random_point(),
                     ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 100000),
                     random_duration());
         send_random(390);
         drain();
      end

      if (fails == 0 && pending == 0)
         $display("takeoff_smoothstep_trajectory_tb: done, clean");
      else
         $display("takeoff_smoothstep_trajectory_tb: done, errors");
      $finish;
   end

endmodule
